// ===== hdl/pose_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// pose frame receiver assertion macros
// shared assertion wrappers, removed when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef POSE_FRAME_RECEIVER_MACROS_SVH
`define POSE_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH
// checked outside reset only
`define PFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define PFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PFR_ASSERT(label, prop, msg)
`define PFR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// constants and types shared by the pose frame receiver
// ----------------------------------------------------------------------------
package pfr_pkg;

    // frame delimiters
    localparam logic [7:0] HDR_FIRST  = 8'h0D;
    localparam logic [7:0] HDR_SECOND = 8'h0A;
    localparam logic [7:0] TRL_FIRST  = 8'h0A;
    localparam logic [7:0] TRL_SECOND = 8'h0D;

    // payload geometry
    localparam int PAYLOAD_LEN  = 24;
    localparam int IDX_W        = $clog2(PAYLOAD_LEN);
    localparam int PAYLOAD_BITS = PAYLOAD_LEN * 8;
    localparam int WORD_BITS    = 32;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);

    // receive phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_HDR2    = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_TRL1    = 5'b01000,
        PH_TRL2    = 5'b10000
    } pfr_phase_t;

    // frame status from the deframer to the top level
    typedef struct packed {
        logic                    frame_ok;
        logic [PAYLOAD_BITS-1:0] payload;
    } pfr_frame_t;

endpackage

// ===== hdl/pfr_deframer.sv =====
// ----------------------------------------------------------------------------
// pfr_deframer
// phase tracking and payload capture for one byte per enabled cycle
// ----------------------------------------------------------------------------
`include "pose_frame_receiver_macros.svh"

module pfr_deframer
    import pfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output pfr_frame_t frame
);

    pfr_phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;

    // next phase, payload index and payload
    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        payload_next = payload_reg;
        if (byte_en) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                end
                PH_HDR2: begin
                    if (rx_byte == HDR_SECOND) begin
                        idx_next   = '0;
                        phase_next = PH_PAYLOAD;
                    end else if (rx_byte != HDR_FIRST) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    // newest byte enters at the top, byte 0 ends at the bottom
                    payload_next = {rx_byte, payload_reg[PAYLOAD_BITS-1:8]};
                    if (idx_reg == IDX_LAST) begin
                        idx_next   = '0;
                        phase_next = PH_TRL1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                PH_TRL1: begin
                    phase_next = (rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
                end
                PH_TRL2: begin
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                    idx_next   = '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // payload shift register
    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

    // good frame on the closing trailer byte
    assign frame.frame_ok = byte_en && (phase_reg == PH_TRL2) && (rx_byte == TRL_SECOND);
    assign frame.payload  = payload_reg;

    `PFR_ASSERT(a_idx_only_in_payload, (idx_reg != '0) |-> (phase_reg == PH_PAYLOAD), "payload index set outside payload phase")
    `PFR_ASSERT(a_last_byte_to_trailer, (byte_en && phase_reg == PH_PAYLOAD && idx_reg == IDX_LAST) |=> (phase_reg == PH_TRL1 && idx_reg == '0), "last payload byte did not move to trailer")
    `PFR_ASSERT(a_idx_in_range, idx_reg <= IDX_LAST, "payload index out of range")

endmodule

// ===== hdl/pose_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// pose_frame_receiver
// serial frame deframer: header 0D 0A, 24 payload bytes, trailer 0A 0D;
// a good frame yields six little-endian 32-bit pose words
// ----------------------------------------------------------------------------
//  channel  | ports                      | carries
//  ---------+----------------------------+---------------------------------
//  s_       | s_valid s_ready s_rx_byte  | one received serial byte
//  m_       | m_valid m_ready m_*_bits   | six pose words per good frame
//
//  one byte per cycle while the result register is not blocked: input register,
//  then phase update and result register; result valid once the closing byte
//  has passed the input register into the result register, and it can be taken as soon as it is valid
//  a full result register stalls the input register only while m_ready is low
//  aresetn (synchronous) returns to header hunt and empties both registers
// ----------------------------------------------------------------------------
`include "pose_frame_receiver_macros.svh"

module pose_frame_receiver
    import pfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_yaw_bits,
    output logic [31:0] m_pitch_bits,
    output logic [31:0] m_roll_bits,
    output logic [31:0] m_x_bits,
    output logic [31:0] m_y_bits,
    output logic [31:0] m_rate_bits
);

    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              in_byte_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;
    logic                    advance;
    pfr_frame_t              frame;

    // stage moves whenever the result register is free or draining
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    // input register
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // phase tracking and payload capture
    pfr_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (in_valid_reg && advance),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    // result register
    assign out_valid_next = advance ? frame.frame_ok : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame.frame_ok) begin
            out_payload_reg <= frame.payload;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_yaw_bits   = out_payload_reg[0*WORD_BITS +: WORD_BITS];
    assign m_pitch_bits = out_payload_reg[1*WORD_BITS +: WORD_BITS];
    assign m_roll_bits  = out_payload_reg[2*WORD_BITS +: WORD_BITS];
    assign m_x_bits     = out_payload_reg[3*WORD_BITS +: WORD_BITS];
    assign m_y_bits     = out_payload_reg[4*WORD_BITS +: WORD_BITS];
    assign m_rate_bits  = out_payload_reg[5*WORD_BITS +: WORD_BITS];

    `PFR_ASSERT(a_stall_needs_both_full, !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready), "input stalled without a blocked result")
    `PFR_ASSERT(a_result_from_byte, $rose(out_valid_reg) |-> $past(in_valid_reg), "result appeared without a buffered byte")

endmodule

// ===== sim/pose_frame_receiver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_frame_receiver_test
// Streams serial bytes into the deframer and checks every pose result against
// a cycle-free tracker of the framing rules. Directed frames come first,
// covering header repeats, bad delimiters and extreme payload words. Random
// frames, broken frames and line noise follow, under changing idle patterns.
// ----------------------------------------------------------------------------
module pose_frame_receiver_test;
    import pfr_pkg::*;

    localparam int FRAME_LEN    = PAYLOAD_LEN + 4;
    localparam int BYTE_TARGET  = 1700;
    localparam int MIX_SPAN     = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam logic [31:0] GOOD_DELIMS = {HDR_FIRST, HDR_SECOND, TRL_FIRST, TRL_SECOND};

    // which side idles, and how often
    typedef enum logic [1:0] {
        MIX_SENDER_SLOW,
        MIX_RECEIVER_SLOW,
        MIX_NO_IDLE
    } stall_mix_t;

    typedef struct packed {
        logic [7:0] data;
        stall_mix_t mix;
        logic       drain_first;
    } pending_byte_t;

    typedef struct packed {
        logic [31:0] yaw;
        logic [31:0] pitch;
        logic [31:0] roll;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] rate;
    } pose_words_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [31:0] m_yaw_bits;
    logic [31:0] m_pitch_bits;
    logic [31:0] m_roll_bits;
    logic [31:0] m_x_bits;
    logic [31:0] m_y_bits;
    logic [31:0] m_rate_bits;

    pending_byte_t byte_pending[$];
    pose_words_t   pose_expected[$];

    // frame tracker state
    pfr_phase_t rx_phase      = PH_HUNT;
    int         payload_count = 0;
    logic [7:0] payload_bytes [PAYLOAD_LEN];

    stall_mix_t idle_mix      = MIX_SENDER_SLOW;
    bit         byte_accepted = 1'b0;
    int         cycle_count   = 0;
    int         fail_count    = 0;
    int         bytes_sent    = 0;
    int         poses_checked = 0;

    pose_frame_receiver DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_yaw_bits   (m_yaw_bits),
        .m_pitch_bits (m_pitch_bits),
        .m_roll_bits  (m_roll_bits),
        .m_x_bits     (m_x_bits),
        .m_y_bits     (m_y_bits),
        .m_rate_bits  (m_rate_bits)
    );

    always #5 aclk = ~aclk;

    // little-endian word k of the collected payload
    function automatic logic [31:0] le_word(input int k);
        return {payload_bytes[4*k+3], payload_bytes[4*k+2],
                payload_bytes[4*k+1], payload_bytes[4*k]};
    endfunction

    // advance the framing rules by one byte, queue a pose on a good trailer
    task automatic frame_track(input logic [7:0] rx);
        pose_words_t pose;
        case (rx_phase)
            PH_HUNT: begin
                if (rx == HDR_FIRST) rx_phase = PH_HDR2;
            end
            PH_HDR2: begin
                if (rx == HDR_SECOND) begin
                    payload_count = 0;
                    rx_phase = PH_PAYLOAD;
                end else if (rx != HDR_FIRST) begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                payload_bytes[payload_count] = rx;
                payload_count++;
                if (payload_count == PAYLOAD_LEN) begin
                    payload_count = 0;
                    rx_phase = PH_TRL1;
                end
            end
            PH_TRL1: begin
                rx_phase = (rx == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
            end
            PH_TRL2: begin
                rx_phase = PH_HUNT;
                if (rx == TRL_SECOND) begin
                    pose.yaw   = le_word(0);
                    pose.pitch = le_word(1);
                    pose.roll  = le_word(2);
                    pose.x     = le_word(3);
                    pose.y     = le_word(4);
                    pose.rate  = le_word(5);
                    pose_expected.push_back(pose);
                end
            end
            default: begin
                rx_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic check_word(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %08h, actual %08h", field, want, got);
            fail_count++;
        end
    endtask

    // queue one byte; the idle mix follows the position in the stream and
    // the sender drains all results at each change of mix
    task automatic add_byte(input logic [7:0] data);
        pending_byte_t item;
        int            pos;
        pos = byte_pending.size();
        item.data        = data;
        item.mix         = (pos < MIX_SPAN) ? MIX_SENDER_SLOW :
                           (pos < 2 * MIX_SPAN) ? MIX_RECEIVER_SLOW : MIX_NO_IDLE;
        item.drain_first = (pos != 0) && (pos % MIX_SPAN == 0);
        byte_pending.push_back(item);
    endtask

    // queue a frame with the given delimiters, cut after cut_len bytes
    task automatic add_frame(input logic [PAYLOAD_BITS-1:0] body,
                             input logic [31:0] delims, input int cut_len);
        logic [7:0] seq [FRAME_LEN];
        int         i;
        seq[0] = delims[31:24];
        seq[1] = delims[23:16];
        for (i = 0; i < PAYLOAD_LEN; i++) seq[i+2] = body[8*i +: 8];
        seq[FRAME_LEN-2] = delims[15:8];
        seq[FRAME_LEN-1] = delims[7:0];
        for (i = 0; i < cut_len; i++) add_byte(seq[i]);
    endtask

    // driver: new byte and ready at the falling edge
    always @(negedge aclk) begin : drive_ports
        int send_idle_pct;
        int recv_idle_pct;
        pending_byte_t item;
        case (idle_mix)
            MIX_SENDER_SLOW:   begin send_idle_pct = 25; recv_idle_pct = 47; end
            MIX_RECEIVER_SLOW: begin send_idle_pct = 47; recv_idle_pct = 25; end
            default:           begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!s_valid || byte_accepted) begin
                if (byte_pending.size() != 0
                        && !(byte_pending[0].drain_first && pose_expected.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    item = byte_pending.pop_front();
                    idle_mix = item.mix;
                    s_rx_byte <= item.data;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: transfers seen at the rising edge
    always @(posedge aclk) begin : watch_ports
        pose_words_t seen;
        pose_words_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end else begin
            byte_accepted = aresetn && s_valid && s_ready;
            // result check
            if (aresetn && m_valid && m_ready) begin
                seen = {m_yaw_bits, m_pitch_bits, m_roll_bits,
                        m_x_bits, m_y_bits, m_rate_bits};
                if (pose_expected.size() == 0) begin
                    $error("pose result with none expected: yaw_bits %08h", seen.yaw);
                    fail_count++;
                end else begin
                    want = pose_expected.pop_front();
                    check_word("yaw_bits",   want.yaw,   seen.yaw);
                    check_word("pitch_bits", want.pitch, seen.pitch);
                    check_word("roll_bits",  want.roll,  seen.roll);
                    check_word("x_bits",     want.x,     seen.x);
                    check_word("y_bits",     want.y,     seen.y);
                    check_word("rate_bits",  want.rate,  seen.rate);
                    poses_checked++;
                end
            end
            // byte transfer into the tracker
            if (byte_accepted) begin
                frame_track(s_rx_byte);
                bytes_sent++;
            end
        end
    end

    // stimulus and end of run
    initial begin : run_script
        logic [PAYLOAD_BITS-1:0] body;
        logic [31:0]             delims;
        logic [7:0]              good_val;
        logic [7:0]              bad_val;
        int                      sel;
        int                      pos;
        int                      i;

        // bytes the hunt ignores, then a stray CR followed by junk
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(HDR_SECOND);
        add_byte(HDR_FIRST);
        add_byte(8'h55);

        // repeated CR before LF, payload with all-zero and all-one words
        // and delimiter values inside the payload
        for (i = 0; i < PAYLOAD_LEN; i++) begin
            case (i % 4)
                0: body[8*i +: 8] = HDR_FIRST;
                1: body[8*i +: 8] = HDR_SECOND;
                2: body[8*i +: 8] = TRL_FIRST;
                default: body[8*i +: 8] = TRL_SECOND;
            endcase
        end
        body[31:0]  = 32'h0000_0000;
        body[63:32] = 32'hFFFF_FFFF;
        add_byte(HDR_FIRST);
        add_byte(HDR_FIRST);
        add_frame(body, GOOD_DELIMS, FRAME_LEN);

        // walking one per byte; first trailer byte is CR, then a lone LF
        for (i = 0; i < PAYLOAD_LEN; i++) body[8*i +: 8] = 8'h01 << (i % 8);
        add_frame(body, {HDR_FIRST, HDR_SECOND, TRL_SECOND, TRL_FIRST}, FRAME_LEN);

        // good frame, then one whose last trailer byte is wrong, then another good frame
        add_frame(~body, GOOD_DELIMS, FRAME_LEN);
        add_frame(body, {HDR_FIRST, HDR_SECOND, TRL_FIRST, TRL_FIRST}, FRAME_LEN);
        add_frame(~body, GOOD_DELIMS, FRAME_LEN);

        // random part: mostly good frames with random content
        while (byte_pending.size() < BYTE_TARGET) begin
            for (i = 0; i < PAYLOAD_LEN; i++) begin
                case ($urandom_range(9))
                    0: body[8*i +: 8] = HDR_FIRST;
                    1: body[8*i +: 8] = HDR_SECOND;
                    2: body[8*i +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                    default: body[8*i +: 8] = 8'($urandom_range(255));
                endcase
            end
            delims = GOOD_DELIMS;
            sel = $urandom_range(99);
            if (sel < 70) begin
                if ($urandom_range(4) == 0) add_byte(HDR_FIRST);
                add_frame(body, delims, FRAME_LEN);
            end else if (sel < 80) begin
                // one delimiter byte wrong
                pos = $urandom_range(3);
                good_val = delims[8*(3-pos) +: 8];
                do begin
                    if ($urandom_range(1) != 0)
                        bad_val = ($urandom_range(1) != 0) ? HDR_FIRST : HDR_SECOND;
                    else
                        bad_val = 8'($urandom_range(255));
                end while (bad_val == good_val);
                delims[8*(3-pos) +: 8] = bad_val;
                add_frame(body, delims, FRAME_LEN);
            end else if (sel < 88) begin
                add_frame(body, delims, $urandom_range(FRAME_LEN - 1, 1));
            end else begin
                repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
            end
        end

        // reset, released at a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for the last transfer, then for the last result
        while (byte_pending.size() != 0 || s_valid) @(negedge aclk);
        while (pose_expected.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);

        $display("sent %0d serial bytes, checked %0d pose frames", bytes_sent, poses_checked);
        $display("idle mixes: sender slow, receiver slow, then none, with drains between");
        if (fail_count == 0 && pose_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
